/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, disabled while rst_n is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, but also checked while in reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/mtse_pkg.sv */
// ----------------------------------------------------------------------------
// mtse_pkg
// Types and constants shared by the multitouch slot event encoder.
// ----------------------------------------------------------------------------
package mtse_pkg;

  localparam int SLOT_COUNT = 10;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int TID_W      = 31;

  localparam logic [2:0] CMD_DOWN   = 3'd0;
  localparam logic [2:0] CMD_MOVE   = 3'd1;
  localparam logic [2:0] CMD_UP     = 3'd2;
  localparam logic [2:0] CMD_CANCEL = 3'd3;
  localparam logic [2:0] CMD_ALL    = 3'd4;
  localparam logic [2:0] CMD_KEY    = 3'd5;

  localparam logic [1:0] EV_SYN = 2'd0;
  localparam logic [1:0] EV_KEY = 2'd1;
  localparam logic [1:0] EV_ABS = 2'd3;

  localparam logic [15:0] CODE_BTN_TOUCH = 16'd330;
  localparam logic [15:0] CODE_SLOT      = 16'd47;
  localparam logic [15:0] CODE_TRACK     = 16'd57;
  localparam logic [15:0] CODE_X         = 16'd53;
  localparam logic [15:0] CODE_Y         = 16'd54;
  localparam logic [15:0] CODE_SYN       = 16'd0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_TID, ST_BTN, ST_SLOT, ST_TRACK,
    ST_X, ST_Y, ST_ALL_SLOT, ST_ALL_TRACK, ST_KEY, ST_SYN, ST_STATUS
  } state_t;

  // what the datapath should put in the output register
  typedef enum logic [3:0] {
    EM_NONE, EM_BTN, EM_SLOT, EM_TRACK, EM_UNTRACK, EM_X, EM_Y,
    EM_ALL_SLOT, EM_KEY, EM_SYN, EM_STATUS
  } emit_t;

  typedef struct packed {
    logic  load;       // capture input word, reset scan
    logic  scan_step;  // examine one slot
    logic  ptr_clr;    // slot pointer back to slot 0, clear tid hit
    logic  tid_step;   // examine one slot for tracking id use
    logic  tid_bump;   // advance candidate tracking id, restart tid scan
    logic  all_next;   // advance cancel-all slot pointer
    emit_t emit;
    logic  emit_last;
    logic  emit_ok;
    logic  commit;     // apply the state change of the command
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic             scan_done;
    logic             found;
    logic             free_found;
    logic [CNT_W-1:0] active;
    logic             tid_done;
    logic             tid_hit;
    logic             all_done;   // no active slot at or after pointer
    logic [6:0]       room;
    logic             key_ok;
    logic             out_busy;
  } dp_stat_t;

endpackage

/* hdl/mtse_datapath.sv */
// ----------------------------------------------------------------------------
// mtse_datapath
// Slot table, scan counters, tracking id search and output register.
// ----------------------------------------------------------------------------
module mtse_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_cmd,
  input  logic [63:0]         in_ident,
  input  logic [31:0]         in_px,
  input  logic [31:0]         in_py,
  input  logic [15:0]         in_kcode,
  input  logic [31:0]         in_kval,
  input  logic [6:0]          in_room,
  input  mtse_pkg::dp_cmd_t   cmd_i,
  output mtse_pkg::dp_stat_t  stat_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [55:0]         out_tdata,
  output logic                out_tlast
);
  import mtse_pkg::*;

  logic [SLOT_COUNT-1:0] act_r, act_nxt;
  logic [63:0]           sid_r [SLOT_COUNT];
  logic [TID_W-1:0]      stid_r [SLOT_COUNT];
  logic [TID_W-1:0]      ntid_r;

  logic [2:0]  cmd_r;
  logic [63:0] ident_r;
  logic [31:0] px_r, py_r, kval_r;
  logic [15:0] kcode_r;
  logic [6:0]  room_r;

  logic [CNT_W-1:0] ptr_r, active_r;
  logic [SLOT_W-1:0] idx_r, free_r;
  logic found_r, free_found_r;
  logic [TID_W-1:0] track_r;
  logic tid_hit_r;
  logic [SLOT_W-1:0] ptr_s;

  logic        ov_r;
  logic [55:0] od_r;
  logic        ol_r;

  assign ptr_s = ptr_r[SLOT_W-1:0];

  // first active slot at or after ptr for cancel all
  logic             all_any;
  logic [SLOT_W-1:0] all_idx;
  always_comb begin
    all_any = 1'b0;
    all_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (act_r[i] && (CNT_W'(i) >= ptr_r)) begin
        all_any = 1'b1;
        all_idx = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      ntid_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= (cmd_i.emit != EM_NONE) || (ov_r && !out_tready);
      if (cmd_i.commit && cmd_r == CMD_DOWN) ntid_r <= track_r + 1'b1;
    end
  end

  always_comb begin
    act_nxt = act_r;
    if (cmd_i.commit) begin
      unique case (cmd_r)
        CMD_DOWN:              act_nxt[free_r] = 1'b1;
        CMD_UP, CMD_CANCEL:    act_nxt[idx_r] = 1'b0;
        CMD_ALL:               act_nxt = '0;
        default:               act_nxt = act_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_cmd; ident_r <= in_ident; px_r <= in_px; py_r <= in_py;
      kcode_r <= in_kcode; kval_r <= in_kval; room_r <= in_room;
      ptr_r <= '0; active_r <= '0; found_r <= 1'b0; free_found_r <= 1'b0;
      idx_r <= '0; free_r <= '0; track_r <= ntid_r; tid_hit_r <= 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (act_r[ptr_s]) begin
        active_r <= active_r + 1'b1;
        if (sid_r[ptr_s] == ident_r) begin
          found_r <= 1'b1;
          idx_r   <= ptr_s;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_r       <= ptr_s;
      end
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd_i.ptr_clr) begin
      ptr_r     <= '0;
      tid_hit_r <= 1'b0;
    end
    if (cmd_i.tid_step) begin
      if (act_r[ptr_s] && stid_r[ptr_s] == track_r) tid_hit_r <= 1'b1;
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd_i.tid_bump) begin
      track_r   <= track_r + 1'b1;
      tid_hit_r <= 1'b0;
      ptr_r     <= '0;
    end
    if (cmd_i.all_next) ptr_r <= CNT_W'(all_idx) + 1'b1;
    if (cmd_i.commit && cmd_r == CMD_DOWN) begin
      sid_r[free_r]  <= ident_r;
      stid_r[free_r] <= track_r;
    end
  end

  // output word build
  logic [1:0]  e_type;
  logic [15:0] e_code;
  logic [31:0] e_val;
  logic        e_has;
  always_comb begin
    e_has = 1'b1; e_type = EV_ABS; e_code = CODE_SYN; e_val = '0;
    unique case (cmd_i.emit)
      EM_BTN: begin
        e_type = EV_KEY; e_code = CODE_BTN_TOUCH;
        e_val  = (cmd_r == CMD_DOWN) ? 32'd1 : 32'd0;
      end
      EM_SLOT: begin
        e_code = CODE_SLOT;
        e_val  = 32'((cmd_r == CMD_DOWN) ? free_r : idx_r);
      end
      EM_TRACK:    begin e_code = CODE_TRACK; e_val = {1'b0, track_r}; end
      EM_UNTRACK:  begin e_code = CODE_TRACK; e_val = '1; end
      EM_X:        begin e_code = CODE_X; e_val = px_r; end
      EM_Y:        begin e_code = CODE_Y; e_val = py_r; end
      EM_ALL_SLOT: begin e_code = CODE_SLOT; e_val = 32'(all_idx); end
      EM_KEY:      begin e_type = EV_KEY; e_code = kcode_r; e_val = kval_r; end
      EM_SYN:      e_type = EV_SYN;
      EM_STATUS:   begin e_has = 1'b0; e_type = EV_SYN; end
      default:     e_has = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit != EM_NONE) begin
      od_r <= {4'd0, cmd_i.emit_ok, e_val, e_code, e_type, e_has};
      ol_r <= cmd_i.emit_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  always_comb begin
    stat_o.cmd        = cmd_r;
    stat_o.scan_done  = (ptr_r == CNT_W'(SLOT_COUNT));
    stat_o.found      = found_r;
    stat_o.free_found = free_found_r;
    stat_o.active     = active_r;
    stat_o.tid_done   = (ptr_r == CNT_W'(SLOT_COUNT)) || tid_hit_r;
    stat_o.tid_hit    = tid_hit_r;
    stat_o.all_done   = !all_any;
    stat_o.room       = room_r;
    stat_o.key_ok     = (kval_r <= 32'd2);
    stat_o.out_busy   = ov_r && !out_tready;
  end

endmodule

/* hdl/mtse_ctrl.sv */
// ----------------------------------------------------------------------------
// mtse_ctrl
// Command sequencer: scan, decide, tracking id search, packet emission.
// ----------------------------------------------------------------------------
module mtse_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  mtse_pkg::dp_stat_t stat_i,
  output mtse_pkg::dp_cmd_t  cmd_o
);
  import mtse_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;
  logic   ok_r, ok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
    end
  end

  logic       is_down, is_end, is_touch;
  logic [6:0] plen;
  always_comb begin
    is_down  = stat_i.cmd == CMD_DOWN;
    is_end   = stat_i.cmd == CMD_UP || stat_i.cmd == CMD_CANCEL;
    is_touch = is_down || stat_i.cmd == CMD_MOVE || is_end;
    if (is_down)      plen = (stat_i.active == '0) ? 7'd6 : 7'd5;
    else if (is_end)  plen = (stat_i.active == CNT_W'(1)) ? 7'd4 : 7'd3;
    else if (stat_i.cmd == CMD_ALL) plen = 7'(stat_i.active) * 7'd2 + 7'd2;
    else              plen = 7'd4;
  end

  always_comb begin
    state_nxt = state_r;
    ok_nxt    = ok_r;
    cmd_o     = '0;
    cmd_o.emit = EM_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_done) state_nxt = ST_DECIDE;
        else cmd_o.scan_step = 1'b1;
      end
      ST_DECIDE: begin
        ok_nxt    = 1'b0;
        state_nxt = ST_STATUS;
        if (is_touch) begin
          if (is_down ? (!stat_i.found && stat_i.free_found) : stat_i.found) begin
            if (stat_i.room >= plen) begin
              ok_nxt = 1'b1;
              if (is_down) state_nxt = ST_TID;
              else if (is_down && stat_i.active == '0 ||
                       is_end && stat_i.active == CNT_W'(1)) state_nxt = ST_BTN;
              else state_nxt = ST_SLOT;
            end
          end
        end else if (stat_i.cmd == CMD_ALL) begin
          if (stat_i.active == '0) ok_nxt = 1'b1;
          else if (stat_i.room >= plen) begin
            ok_nxt = 1'b1; state_nxt = ST_BTN;
          end
        end else if (stat_i.cmd == CMD_KEY) begin
          if (stat_i.key_ok && stat_i.room >= 7'd2) begin
            ok_nxt = 1'b1; state_nxt = ST_KEY;
          end
        end
      end
      ST_TID: begin
        // ptr was cleared on leaving decide; a hit moves to the next candidate
        if (stat_i.tid_hit) cmd_o.tid_bump = 1'b1;
        else if (stat_i.tid_done) begin
          state_nxt = (stat_i.active == '0) ? ST_BTN : ST_SLOT;
        end else cmd_o.tid_step = 1'b1;
      end
      default: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit_ok = ok_r;
          unique case (state_r)
            ST_BTN: begin
              cmd_o.emit = EM_BTN;
              state_nxt  = (stat_i.cmd == CMD_ALL) ? ST_ALL_SLOT : ST_SLOT;
            end
            ST_SLOT: begin
              cmd_o.emit = EM_SLOT;
              if (is_down) state_nxt = ST_TRACK;
              else if (is_end) state_nxt = ST_TRACK;
              else state_nxt = ST_X;
            end
            ST_TRACK: begin
              cmd_o.emit = is_down ? EM_TRACK : EM_UNTRACK;
              state_nxt  = is_down ? ST_X : ST_SYN;
            end
            ST_X: begin cmd_o.emit = EM_X; state_nxt = ST_Y; end
            ST_Y: begin cmd_o.emit = EM_Y; state_nxt = ST_SYN; end
            ST_ALL_SLOT: begin
              if (stat_i.all_done) state_nxt = ST_SYN;
              else begin cmd_o.emit = EM_ALL_SLOT; state_nxt = ST_ALL_TRACK; end
            end
            ST_ALL_TRACK: begin
              cmd_o.emit = EM_UNTRACK; cmd_o.all_next = 1'b1; state_nxt = ST_ALL_SLOT;
            end
            ST_KEY: begin cmd_o.emit = EM_KEY; state_nxt = ST_SYN; end
            ST_SYN: begin
              cmd_o.emit = EM_SYN; cmd_o.emit_last = 1'b1;
              cmd_o.commit = 1'b1; state_nxt = ST_IDLE;
            end
            ST_STATUS: begin
              cmd_o.emit = EM_STATUS; cmd_o.emit_last = 1'b1; state_nxt = ST_IDLE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
    endcase
    // tracking id search and cancel all walk the slots from slot 0
    if (state_r == ST_DECIDE) begin
      cmd_o.ptr_clr = 1'b1;
    end
  end

  `ASSERT_CLK(a_ready_idle, clk, rst_n, in_tready |-> state_r == ST_IDLE, "ready outside idle")
  `ASSERT_CLK(a_commit_ok, clk, rst_n, cmd_o.commit |-> ok_r, "commit on refused command")
  `ASSERT_CLK(a_no_emit_busy, clk, rst_n, (cmd_o.emit != EM_NONE) |-> !stat_i.out_busy, "emit over held word")

endmodule

/* hdl/multitouch_slot_event_encoder.sv */
// ----------------------------------------------------------------------------
// multitouch_slot_event_encoder
// Slot table based multitouch type-B event packet encoder.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// in_      | tvalid/tready       | tdata: command, identity, pos_x, pos_y, key_code,
//          |                     |        key_value, queue_room
// out_     | tvalid/tready/tlast | tdata: has_event, event_type, event_code,
//          |                     |        event_value, ok
// One command at a time. After the accept cycle the sequencer scans every slot
// and decides, then emits its output words back to back while out_tready is high;
// cancel all ends its slot walk with a state that emits no word.
// A down command first searches for an unused tracking id, one candidate at a time.
// Output stalls hold the sequencer; reset clears slots and the tid counter.
module multitouch_slot_event_encoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0], identity[66:3], pos_x[98:67], pos_y[130:99],
  // key_code[146:131], key_value[178:147], queue_room[185:179]
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // has_event[0], event_type[2:1], event_code[18:3], event_value[50:19], ok[51]
  output logic [55:0]  out_tdata,
  output logic         out_tlast
);
  import mtse_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mtse_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  mtse_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_cmd(in_tdata[2:0]), .in_ident(in_tdata[66:3]),
    .in_px(in_tdata[98:67]), .in_py(in_tdata[130:99]),
    .in_kcode(in_tdata[146:131]), .in_kval(in_tdata[178:147]),
    .in_room(in_tdata[185:179]),
    .cmd_i(cmd), .stat_o(stat),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

endmodule

/* sim/mtse_checker.sv */
// ----------------------------------------------------------------------------
// mtse_checker
// Watches both streams of the multitouch event encoder, predicts each packet
// from its own slot table and compares every output word field by field.
// ----------------------------------------------------------------------------
module mtse_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [55:0]  out_tdata,
  input  logic         out_tlast,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mtse_pkg::*;

  typedef struct packed {
    logic        has_event;
    logic [1:0]  ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
    logic        ok;
    logic        last;
  } ev_word_t;

  ev_word_t   expected_words[$];
  logic       slot_live[SLOT_COUNT];
  logic [63:0] slot_ident[SLOT_COUNT];
  logic [30:0] slot_tid[SLOT_COUNT];
  logic [30:0] tid_next;
  int         mismatches;

  assign fail_count = mismatches;
  assign pending    = expected_words.size();

  function automatic ev_word_t mk(logic h, logic [1:0] t, logic [15:0] c,
                                  logic [31:0] v, logic k, logic l);
    ev_word_t w;
    w.has_event = h; w.ev_type = t; w.ev_code = c; w.ev_value = v;
    w.ok = k; w.last = l;
    return w;
  endfunction

  function automatic bit tid_taken(logic [30:0] id);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (slot_live[i] && slot_tid[i] == id) return 1;
    return 0;
  endfunction

  // builds the packet for one command and updates the slot table
  task automatic encode_command(logic [191:0] d);
    ev_word_t    pkt[$];
    logic [2:0]  cmd;
    logic [63:0] ident;
    logic [31:0] kval;
    logic [6:0]  room;
    int          idx, active;
    logic [30:0] track;
    bit          is_down, is_end, accepted;
    cmd = d[2:0]; ident = d[66:3]; kval = d[178:147]; room = d[185:179];
    accepted = 0; idx = -1; active = 0; track = tid_next;
    is_down = (cmd == CMD_DOWN);
    is_end  = (cmd == CMD_UP || cmd == CMD_CANCEL);
    if (cmd <= CMD_CANCEL) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        if (slot_live[i]) begin
          active++;
          if (slot_ident[i] == ident) idx = i;
        end
      if (is_down) begin
        if (idx >= 0) idx = -2;
        else
          for (int i = 0; i < SLOT_COUNT; i++)
            if (!slot_live[i]) begin idx = i; break; end
      end
      if (idx >= 0) begin
        if (is_down && active == 0) pkt.push_back(mk(1, EV_KEY, CODE_BTN_TOUCH, 1, 1, 0));
        if (is_end && active == 1) pkt.push_back(mk(1, EV_KEY, CODE_BTN_TOUCH, 0, 1, 0));
        pkt.push_back(mk(1, EV_ABS, CODE_SLOT, idx, 1, 0));
        if (is_down) begin
          while (tid_taken(track)) track = track + 1;
          pkt.push_back(mk(1, EV_ABS, CODE_TRACK, {1'b0, track}, 1, 0));
        end
        if (is_end) pkt.push_back(mk(1, EV_ABS, CODE_TRACK, 32'hffffffff, 1, 0));
        else begin
          pkt.push_back(mk(1, EV_ABS, CODE_X, d[98:67], 1, 0));
          pkt.push_back(mk(1, EV_ABS, CODE_Y, d[130:99], 1, 0));
        end
        pkt.push_back(mk(1, EV_SYN, CODE_SYN, 0, 1, 0));
        if (room >= pkt.size()) begin
          accepted = 1;
          if (is_down) begin
            slot_live[idx] = 1; slot_ident[idx] = ident; slot_tid[idx] = track;
            tid_next = track + 1;
          end
          if (is_end) slot_live[idx] = 0;
        end
      end
      if (!accepted) pkt = {mk(0, EV_SYN, 0, 0, 0, 1)};
    end else if (cmd == CMD_ALL) begin
      pkt.push_back(mk(1, EV_KEY, CODE_BTN_TOUCH, 0, 1, 0));
      for (int i = 0; i < SLOT_COUNT; i++)
        if (slot_live[i]) begin
          pkt.push_back(mk(1, EV_ABS, CODE_SLOT, i, 1, 0));
          pkt.push_back(mk(1, EV_ABS, CODE_TRACK, 32'hffffffff, 1, 0));
        end
      if (pkt.size() == 1) pkt = {mk(0, EV_SYN, 0, 0, 1, 1)};
      else begin
        pkt.push_back(mk(1, EV_SYN, CODE_SYN, 0, 1, 0));
        if (room < pkt.size()) pkt = {mk(0, EV_SYN, 0, 0, 0, 1)};
        else for (int i = 0; i < SLOT_COUNT; i++) slot_live[i] = 0;
      end
    end else if (cmd == CMD_KEY && kval <= 2 && room >= 2) begin
      pkt.push_back(mk(1, EV_KEY, d[146:131], kval, 1, 0));
      pkt.push_back(mk(1, EV_SYN, CODE_SYN, 0, 1, 0));
    end else begin
      pkt = {mk(0, EV_SYN, 0, 0, 0, 1)};
    end
    pkt[pkt.size()-1].last = 1;
    foreach (pkt[i]) expected_words.push_back(pkt[i]);
  endtask

  always @(posedge clk) begin
    ev_word_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_live[i] = 0; slot_ident[i] = '0; slot_tid[i] = '0;
      end
      tid_next = '0;
      mismatches = 0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = mk(out_tdata[0], out_tdata[2:1], out_tdata[18:3], out_tdata[50:19],
                 out_tdata[51], out_tlast);
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: unexpected word %h", $realtime, got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: word mismatch exp has=%b t=%0d c=%0d v=%h ok=%b l=%b",
                       $realtime, want.has_event, want.ev_type, want.ev_code,
                       want.ev_value, want.ok, want.last,
                       " got has=%b t=%0d c=%0d v=%h ok=%b l=%b",
                       got.has_event, got.ev_type, got.ev_code, got.ev_value,
                       got.ok, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) encode_command(in_tdata);
    end
  end
endmodule

/* sim/tb_multitouch_slot_event_encoder.sv */
// ----------------------------------------------------------------------------
// tb_multitouch_slot_event_encoder
// Drives directed and random touch, cancel and key commands with random
// stalls on both streams; the checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_multitouch_slot_event_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import mtse_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [55:0]  out_tdata;
  logic         out_tlast;
  int           fail_count, pending;
  int           cycles = 0;
  bit           hold_off = 0;
  int           n_cmds = 0;
  logic [63:0]  ids[6];

  localparam int LIMIT = 2000000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  multitouch_slot_event_encoder DUT (.*);

  mtse_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout with %0d words outstanding", pending);
      $display("tb_multitouch_slot_event_encoder failed");
      $finish;
    end
  end

  // receiver: random stall per word, plus one long hold
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      w = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) w = 0;
      out_tready <= (w == 0);
      if (w != 0) begin
        repeat (w) @(posedge clk);
        out_tready <= 1;
      end
      @(posedge clk iff (out_tvalid && out_tready));
    end
  end

  task automatic send(logic [2:0] cmd, logic [63:0] ident, logic [31:0] px,
                      logic [31:0] py, logic [15:0] kc, logic [31:0] kv,
                      logic [6:0] room, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 6) : 0;
    if (w != 0) begin
      in_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    in_tdata  <= {6'd0, room, kv, kc, py, px, ident, cmd};
    in_tvalid <= 1;
    @(posedge clk iff in_tready);
    n_cmds++;
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 3))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0]  cmd;
    logic [6:0]  room;
    logic [31:0] kv;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (ids[i]) ids[i] = {$urandom, $urandom};
    ids[0] = '0; ids[1] = '1;

    // directed
    send(CMD_ALL, 0, 0, 0, 0, 0, 64, 0);                      // nothing active
    send(CMD_MOVE, ids[0], 0, 0, 0, 0, 64, 0);                // unknown identity
    send(CMD_DOWN, ids[0], 32'h80000000, 32'h7fffffff, 0, 0, 3, 0); // no room
    send(CMD_DOWN, ids[0], 32'h80000000, 32'h7fffffff, 0, 0, 6, 0);
    send(CMD_DOWN, ids[0], 1, 2, 0, 0, 64, 0);                // known identity
    for (int i = 1; i < 11; i++)
      send(CMD_DOWN, (i < 10) ? {32'd0, $urandom} : ids[1], 3, 4, 0, 0, 64, 0);
    send(CMD_MOVE, ids[0], 32'h7fffffff, 32'h80000000, 0, 0, 4, 0);
    send(CMD_MOVE, ids[0], 32'h7fffffff, 32'h80000000, 0, 0, 64, 0);
    send(CMD_UP, ids[0], 0, 0, 0, 0, 64, 0);
    send(CMD_ALL, 0, 0, 0, 0, 0, 20, 0);                      // exactly enough room
    send(CMD_ALL, 0, 0, 0, 0, 0, 127, 0);
    send(CMD_KEY, 0, 0, 0, 16'hffff, 2, 2, 0);
    send(CMD_KEY, 0, 0, 0, 16'h0000, 0, 1, 0);
    send(CMD_KEY, 0, 0, 0, 16'h1234, 32'hffffffff, 64, 0);
    send(3'd6, '1, 0, 0, 0, 0, 64, 0);
    send(3'd7, '1, 0, 0, 0, 0, 64, 0);
    send(CMD_DOWN, ids[2], 0, 0, 0, 0, 64, 0);
    send(CMD_CANCEL, ids[2], 0, 0, 0, 0, 64, 0);

    // long receiver hold while commands keep coming
    hold_off = 1;
    for (int i = 0; i < 8; i++) send(CMD_KEY, 0, 0, 0, 16'($urandom), 1, 64, 0);

    // random: mostly well-formed touch traffic over a small identity pool
    for (int n = 0; n < 400; n++) begin
      if (n == 200) begin
        in_tvalid <= 0;
        @(posedge clk iff (pending == 0));
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:   cmd = CMD_DOWN;
        6, 7, 8, 9, 10, 11: cmd = CMD_MOVE;
        12, 13, 14:         cmd = CMD_UP;
        15:                 cmd = CMD_CANCEL;
        16:                 cmd = CMD_ALL;
        17, 18:             cmd = CMD_KEY;
        default:            cmd = 3'($urandom_range(6, 7));
      endcase
      room = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'd64;
      kv = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 2));
      send(cmd, ($urandom_range(0, 15) == 0) ? {$urandom, $urandom} : ids[$urandom_range(0, 5)],
           rnd32(), rnd32(), 16'($urandom), kv, room, 1);
    end
    in_tvalid <= 0;

    @(posedge clk iff (pending == 0));
    repeat (100) @(posedge clk);
    $display("ran %0d commands: touch down/move/up/cancel, cancel all, keys, bad codes,",
             n_cmds);
    $display("queue room limits and full slot table, under random and long stalls");
    if (fail_count == 0) begin
      $display("tb_multitouch_slot_event_encoder passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb_multitouch_slot_event_encoder failed");
    end
    $finish;
  end
endmodule
